@@ rtl/sawflg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sawflg_pkg
// Shared constants and types of the sawtooth flanger delay core.
// ----------------------------------------------------------------------------
package sawflg_pkg;

	localparam int DELAY_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int FRAC_W      = 16;
	localparam int POS_W       = ADDR_W + FRAC_W;
	localparam int DLY_W       = 34;
	localparam int SAMPLE_W    = 24;
	localparam int PHASE_W     = 32;
	localparam int DEPTH_W     = 27;
	localparam int PREDLY_W    = 28;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd8948;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PREDELAY   = 2'd2;

	// one frame as handed from the front to the back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [ADDR_W-1:0]          wr_addr;
		logic [ADDR_W-1:0]          rd_addr0;
		logic [ADDR_W-1:0]          rd_addr1;
		logic [FRAC_W-1:0]          frac;
		logic                       written0;
		logic                       written1;
	} frame_cmd_t;

endpackage
`default_nettype wire

@@ rtl/sawflg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sawflg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sawflg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/sawflg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sawflg_front
// Config registers, LFO phase and write pointer; turns each frame into a
// read-position command for the back end.
// ----------------------------------------------------------------------------
module sawflg_front
	import sawflg_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_left,
	input  wire logic signed [SAMPLE_W-1:0] sample_right,
	output logic                            push,
	output frame_cmd_t                      push_cmd,
	input  wire logic                       full
);

	logic [PHASE_W-1:0]  phase_step_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [PREDLY_W-1:0] predelay_q;
	logic [PHASE_W-1:0]  lfo_phase_q;
	logic [ADDR_W-1:0]   write_idx_q;
	logic                wrapped_q;

	logic                       valid_s1;
	logic signed [59:0]         prod_s1;
	logic signed [SAMPLE_W-1:0] left_s1;
	logic signed [SAMPLE_W-1:0] right_s1;
	logic [ADDR_W-1:0]          wi_s1;
	logic                       wrap_s1;

	logic                accept;
	logic signed [59:0]  sweep_prod;
	logic [DLY_W-1:0]    delay;
	logic [DLY_W-1:0]    pos_full;
	logic [POS_W-1:0]    pos;
	logic [ADDR_W-1:0]   idx0;
	logic [ADDR_W-1:0]   idx1;

	assign in_ready = !valid_s1;
	assign accept   = in_valid && in_ready;

	// depth times the signed sawtooth, registered before the delay sum
	assign sweep_prod = $signed({1'b0, depth_q}) * $signed(lfo_phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RESET;
			depth_q      <= '0;
			predelay_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_W-1:0];
				CFG_DEPTH:      depth_q      <= cfg_data[DEPTH_W-1:0];
				CFG_PREDELAY:   predelay_q   <= cfg_data[PREDLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_phase_q <= '0;
			write_idx_q <= '0;
			wrapped_q   <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				lfo_phase_q <= lfo_phase_q + phase_step_q;
				write_idx_q <= write_idx_q + 1'b1;
				if (&write_idx_q) begin
					wrapped_q <= 1'b1;
				end
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1  <= sweep_prod;
			left_s1  <= sample_left;
			right_s1 <= sample_right;
			wi_s1    <= write_idx_q;
			wrap_s1  <= wrapped_q;
		end
	end

	// read position wraps modulo the store size, a power of two
	assign delay    = DLY_W'(predelay_q) + DLY_W'($signed(prod_s1[59:31]));
	assign pos_full = DLY_W'({wi_s1, {FRAC_W{1'b0}}}) - delay;
	assign pos      = pos_full[POS_W-1:0];
	assign idx0     = pos[POS_W-1:FRAC_W];
	assign idx1     = idx0 + 1'b1;

	assign push = valid_s1 && !full;

	always_comb begin
		push_cmd.left     = left_s1;
		push_cmd.right    = right_s1;
		push_cmd.wr_addr  = wi_s1;
		push_cmd.rd_addr0 = idx0;
		push_cmd.rd_addr1 = idx1;
		push_cmd.frac     = pos[FRAC_W-1:0];
		// entries not yet written since reset read as zero
		push_cmd.written0 = wrap_s1 || (idx0 < wi_s1);
		push_cmd.written1 = wrap_s1 || (idx1 < wi_s1);
	end

endmodule
`default_nettype wire

@@ rtl/sawflg_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sawflg_queue
// Two-entry command queue between the front and the back end, head shown
// ahead of the pop.
// ----------------------------------------------------------------------------
module sawflg_queue
	import sawflg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire frame_cmd_t push_cmd,
	output logic            full,
	input  wire logic       pop,
	output logic            empty,
	output frame_cmd_t      head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_cmd_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

@@ rtl/sawflg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sawflg_back
// Reads two neighboring entries from the stereo delay RAM, writes the new
// frame, interpolates both channels and holds the result word.
// ----------------------------------------------------------------------------
module sawflg_back
	import sawflg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  empty,
	input  wire frame_cmd_t            head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [SAMPLE_W-1:0] delayed_left,
	output logic signed [SAMPLE_W-1:0] delayed_right
);

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_W + 1;

	typedef enum logic [1:0] {
		ST_RD0,
		ST_RD1,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t state_q;

	logic                       ram_wr_en;
	logic                       ram_rd_en;
	logic [ADDR_W-1:0]          ram_rd_addr;
	logic [2*SAMPLE_W-1:0]      ram_rd_data;

	logic signed [SAMPLE_W-1:0] a_l_q;
	logic signed [SAMPLE_W-1:0] a_r_q;
	logic signed [PROD_W-1:0]   prod_l_q;
	logic signed [PROD_W-1:0]   prod_r_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_l_q;
	logic signed [SAMPLE_W-1:0] out_r_q;

	logic signed [SAMPLE_W-1:0] rd_l;
	logic signed [SAMPLE_W-1:0] rd_r;
	logic signed [DIFF_W-1:0]   diff_l;
	logic signed [DIFF_W-1:0]   diff_r;
	logic signed [PROD_W-1:0]   rnd_l;
	logic signed [PROD_W-1:0]   rnd_r;
	logic                       slot_free;

	sawflg_ram #(
		.WIDTH (2 * SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (head.wr_addr),
		.wr_data ({head.left, head.right}),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rd_l = ram_rd_data[2*SAMPLE_W-1:SAMPLE_W];
	assign rd_r = ram_rd_data[SAMPLE_W-1:0];

	// first entry read in ST_RD0, second in ST_RD1, new frame written in ST_MUL
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = head.rd_addr0;
		ram_wr_en   = 1'b0;
		unique case (state_q)
			ST_RD0: ram_rd_en = !empty;
			ST_RD1: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = head.rd_addr1;
			end
			ST_MUL: ram_wr_en = 1'b1;
			ST_OUT: ;
			default: ;
		endcase
	end

	// out = a + round(frac * (b - a) / 2^16)
	assign diff_l = (head.written1 ? DIFF_W'(rd_l) : '0) - DIFF_W'(a_l_q);
	assign diff_r = (head.written1 ? DIFF_W'(rd_r) : '0) - DIFF_W'(a_r_q);
	assign rnd_l  = prod_l_q + PROD_W'(32'sd32768);
	assign rnd_r  = prod_r_q + PROD_W'(32'sd32768);

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_OUT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RD0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RD0: begin
					if (!empty) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_RD0;
					end
				end
				default: state_q <= ST_RD0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD1) begin
			a_l_q <= head.written0 ? rd_l : '0;
			a_r_q <= head.written0 ? rd_r : '0;
		end
		if (state_q == ST_MUL) begin
			prod_l_q <= diff_l * $signed({1'b0, head.frac});
			prod_r_q <= diff_r * $signed({1'b0, head.frac});
		end
		if (pop) begin
			out_l_q <= SAMPLE_W'((SAMPLE_W + 2)'(a_l_q) + rnd_l[PROD_W-1:FRAC_W]);
			out_r_q <= SAMPLE_W'((SAMPLE_W + 2)'(a_r_q) + rnd_r[PROD_W-1:FRAC_W]);
		end
	end

	assign out_valid     = out_valid_q;
	assign delayed_left  = out_l_q;
	assign delayed_right = out_r_q;

	// the command at the head stays put until its result is loaded
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_RD0 |-> !empty)
		else $error("queue emptied while a frame was in flight");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr_en && ram_rd_en))
		else $error("delay ram read and write in the same cycle");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> slot_free)
		else $error("result word overwritten before it was taken");

endmodule
`default_nettype wire

@@ rtl/sawtooth_lfo_flanger_delay_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sawtooth_lfo_flanger_delay_core
// Stereo flanger delay swept by a shared sawtooth LFO, wet output only.
// ----------------------------------------------------------------------------
// One stereo frame goes in per word and one delayed frame comes out. The front
// end holds each frame in a register (the depth-times-sawtooth multiply is
// registered before the read position is formed) and takes no new frame until
// it has queued that one for the back end. The back end works on one frame at
// a time: ST_RD0 and ST_RD1 read the two entries through the single read port
// of the delay RAM, ST_MUL writes the new frame and does the interpolation
// multiply, and ST_OUT loads the output word once the result slot is free.
// Entries not yet written since reset read as zero through the write pointer's
// wrap flag, so no RAM clearing pass is needed. Config writes are taken every
// cycle and should be done while the block is idle.
// ----------------------------------------------------------------------------
module sawtooth_lfo_flanger_delay_core
	import sawflg_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_left,
	input  wire logic signed [SAMPLE_W-1:0] sample_right,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      delayed_left,
	output logic signed [SAMPLE_W-1:0]      delayed_right
);

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	frame_cmd_t push_cmd;
	frame_cmd_t head_cmd;

	assign cfg_ready = 1'b1;

	sawflg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.push         (q_push),
		.push_cmd     (push_cmd),
		.full         (q_full)
	);

	sawflg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_cmd)
	);

	sawflg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.head          (head_cmd),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.delayed_left  (delayed_left),
		.delayed_right (delayed_right)
	);

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sawtooth flanger delay core. Stereo words are
// pushed through the core under several LFO, depth and predelay settings with
// random idling on both sides; a bit-exact model of the delay line predicts
// every delayed word, and a scoreboard compares them in order.
// ----------------------------------------------------------------------------
module testbench;
	import sawflg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 150;
	localparam int RANDOM_WORDS   = 1600;
	localparam int DRAIN_CYCLES   = 20;

	class flanger_scoreboard;
		typedef struct {
			bit [SAMPLE_W-1:0] left;
			bit [SAMPLE_W-1:0] right;
		} stereo_t;

		bit [SAMPLE_W-1:0] hist_left [DELAY_DEPTH];
		bit [SAMPLE_W-1:0] hist_right [DELAY_DEPTH];
		bit [ADDR_W-1:0]   wr_ptr;
		bit [PHASE_W-1:0]  lfo_acc;
		bit [PHASE_W-1:0]  step;
		bit [DEPTH_W-1:0]  depth;
		bit [PREDLY_W-1:0] predelay;
		stereo_t           pending_words[$];
		int                errors;

		function new();
			wr_ptr = '0;
			lfo_acc = '0;
			step = PHASE_STEP_RESET;
			depth = '0;
			predelay = '0;
			errors = 0;
			foreach (hist_left[i]) begin
				hist_left[i] = '0;
				hist_right[i] = '0;
			end
		endfunction

		function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PHASE_STEP: step = data[PHASE_W-1:0];
				CFG_DEPTH:      depth = data[DEPTH_W-1:0];
				CFG_PREDELAY:   predelay = data[PREDLY_W-1:0];
				default: ;
			endcase
		endfunction

		// (1-f)*a + f*b, rounded half up
		function bit [SAMPLE_W-1:0] blend(bit [SAMPLE_W-1:0] a, bit [SAMPLE_W-1:0] b,
				bit [FRAC_W-1:0] f);
			longint acc;
			acc = (longint'(65536) - longint'(f)) * longint'($signed(a))
				+ longint'(f) * longint'($signed(b)) + longint'(32768);
			acc = acc >>> FRAC_W;
			return acc[SAMPLE_W-1:0];
		endfunction

		function void note_frame(bit [SAMPLE_W-1:0] l, bit [SAMPLE_W-1:0] r);
			longint          sweep;
			longint          dly;
			longint          pos;
			bit [POS_W-1:0]  rd_pos;
			bit [ADDR_W-1:0] i0;
			bit [ADDR_W-1:0] i1;
			stereo_t         w;
			sweep = longint'(depth) * longint'($signed(lfo_acc));
			dly = longint'(predelay) + (sweep >>> 31);
			pos = longint'(wr_ptr) * 65536 - dly;
			// store size is a power of two, so the low bits are the wrapped position
			rd_pos = pos[POS_W-1:0];
			i0 = rd_pos[POS_W-1:FRAC_W];
			i1 = i0 + 1'b1;
			w.left = blend(hist_left[i0], hist_left[i1], rd_pos[FRAC_W-1:0]);
			w.right = blend(hist_right[i0], hist_right[i1], rd_pos[FRAC_W-1:0]);
			pending_words.push_back(w);
			hist_left[wr_ptr] = l;
			hist_right[wr_ptr] = r;
			wr_ptr = wr_ptr + 1'b1;
			lfo_acc = lfo_acc + step;
		endfunction

		task report_mismatch(string msg);
			if (errors < 50)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
			stereo_t w;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word left %h right %h", l, r));
			end else begin
				w = pending_words.pop_front();
				if (l !== w.left)
					report_mismatch($sformatf("delayed_left %h, want %h", l, w.left));
				if (r !== w.right)
					report_mismatch($sformatf("delayed_right %h, want %h", r, w.right));
			end
		endtask

		function int outstanding();
			return pending_words.size();
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic signed [SAMPLE_W-1:0]   sample_left = '0;
	logic signed [SAMPLE_W-1:0]   sample_right = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0]   delayed_left;
	logic signed [SAMPLE_W-1:0]   delayed_right;

	flanger_scoreboard sb = new();
	bit gap_free = 1'b0;
	bit hold_go = 1'b0;

	sawtooth_lfo_flanger_delay_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.delayed_left (delayed_left),
		.delayed_right(delayed_right)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_free || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit [SAMPLE_W-1:0] rand_sample();
		bit [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'(int'($urandom_range(0, 15)) - 8);
			default: return v[SAMPLE_W-1:0];
		endcase
	endfunction

	// valid stays high across back-to-back words
	task automatic send_frame(input bit [SAMPLE_W-1:0] l, input bit [SAMPLE_W-1:0] r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_left <= l;
		sample_right <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_frame(l, r);
	endtask

	task automatic finish_burst();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic put_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic program_regs(input bit [31:0] st, input bit [31:0] dp,
			input bit [31:0] pd, input bit poke_spare);
		put_reg(CFG_PHASE_STEP, st);
		put_reg(CFG_DEPTH, dp);
		put_reg(CFG_PREDELAY, pd);
		// index past the register list must be ignored
		if (poke_spare)
			put_reg(CFG_SPARE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	initial begin : drain
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_frame(delayed_left, delayed_right);
			if (hold_go) begin
				hold_go = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int        sent;
		int        burst;
		int        phase_no;
		bit [31:0] st;
		bit [31:0] dp;
		bit [31:0] pd;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero delay reads the oldest entries, still zero
		send_frame(24'h7fffff, 24'h800000);
		send_frame(24'h800000, 24'h7fffff);
		send_frame(24'h000000, 24'hffffff);
		send_frame(24'h000001, 24'h400000);
		finish_burst();

		// one whole sample of delay returns the previous word
		program_regs(32'd0, 32'd0, 32'h0001_0000, 1'b0);
		send_frame(24'h800000, 24'h7fffff);
		send_frame(24'h7fffff, 24'h800000);
		send_frame(24'h000001, 24'hffffff);
		send_frame(24'h555555, 24'haaaaaa);
		finish_burst();

		// one-and-a-half-sample delay between extremes exercises rounding
		program_regs(32'd0, 32'd0, 32'h0001_8000, 1'b0);
		send_frame(24'h7fffff, 24'h800000);
		send_frame(24'h800000, 24'h7fffff);
		send_frame(24'h7fffff, 24'h7fffff);
		send_frame(24'h000000, 24'h000000);
		finish_burst();

		// full depth with a flipping sawtooth gives negative delays
		program_regs(32'h8000_0000, 32'h07ff_ffff, 32'd0, 1'b1);
		repeat (4) send_frame(rand_sample(), rand_sample());
		finish_burst();

		// delays beyond the store wrap around; upper register bits dropped
		program_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		repeat (4) send_frame(rand_sample(), rand_sample());
		finish_burst();

		sent = 0;
		phase_no = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 5))
				0: st = 32'd0;
				1: st = 32'hffff_ffff;
				2: st = 32'h8000_0000;
				5: st = $urandom;
				default: st = $urandom_range(1, 32'h0400_0000);
			endcase
			case ($urandom_range(0, 5))
				0: dp = 32'd0;
				1: dp = 32'h07ff_ffff;
				2: dp = 32'hffff_ffff;
				5: dp = $urandom;
				default: dp = $urandom_range(0, 64 << 16);
			endcase
			case ($urandom_range(0, 5))
				0: pd = 32'd0;
				1: pd = 32'h0fff_ffff;
				2: pd = 32'hffff_ffff;
				5: pd = $urandom;
				default: pd = $urandom_range(0, 200 << 16);
			endcase
			program_regs(st, dp, pd, $urandom_range(0, 7) == 0);
			if (phase_no == 3) begin
				// receiver holds off while words keep coming, so the core backs up
				gap_free = 1'b1;
				hold_go = 1'b1;
				burst = 40;
			end else begin
				gap_free = ($urandom_range(0, 5) == 0);
				burst = $urandom_range(20, 120);
			end
			repeat (burst) send_frame(rand_sample(), rand_sample());
			sent += burst;
			finish_burst();
			gap_free = 1'b0;
			phase_no++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
